[sv/gre_pkg.sv]
// ----------------------------------------------------------------------------
// gre_pkg
// Shared types, constants and helpers of the glyph row to e-ink gray unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gre_pkg;

  // cell geometry
  localparam int CELL_W = 8;
  localparam int CELL_H = 16;

  // field widths
  localparam int RGB_W   = 24;
  localparam int ROW_W   = 4;
  localparam int GLYPH_W = 16;
  localparam int KIND_W  = 2;
  localparam int PIX_W   = 8;
  localparam int SUM_W   = 16;
  localparam int LUMA_W  = 8;
  localparam int CFG_IDX_W = 1;

  // luma weights and level thresholds
  localparam logic [SUM_W-1:0] LUMA_R = 16'd54;
  localparam logic [SUM_W-1:0] LUMA_G = 16'd182;
  localparam logic [SUM_W-1:0] LUMA_B = 16'd19;
  localparam logic [LUMA_W-1:0] LUMA_BLACK_MAX = 8'd85;
  localparam logic [LUMA_W-1:0] LUMA_WHITE_MIN = 8'd170;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_FG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_BG = 1'd1;
  localparam logic [RGB_W-1:0] CURSOR_FG_RESET = 24'h000000;
  localparam logic [RGB_W-1:0] CURSOR_BG_RESET = 24'hFFFFFF;

  // width kinds
  localparam logic [KIND_W-1:0] KIND_HALF  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WIDE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RIGHT = 2'd2;

  // bdf padding
  localparam int PAD_HALF   = ((CELL_W + 7) / 8) * 8 - CELL_W;
  localparam int PAD_DOUBLE = ((2 * CELL_W + 7) / 8) * 8 - 2 * CELL_W;
  localparam int PAD_WIDE   = PAD_DOUBLE + CELL_W;

  // underline row, only when it fits the row field
  localparam bit ULINE_REACH = (CELL_H - 1) < (1 << ROW_W);
  localparam logic [ROW_W-1:0] ULINE_ROW = ROW_W'(CELL_H - 1);

  typedef enum logic [1:0] {
    LVL_BLACK  = 2'd0,
    LVL_DITHER = 2'd1,
    LVL_WHITE  = 2'd2
  } lvl_t;

  typedef struct packed {
    logic [SUM_W-1:0]   fg_sum;
    logic [SUM_W-1:0]   bg_sum;
    logic [ROW_W-1:0]   row;
    logic [GLYPH_W-1:0] bits;
    logic [KIND_W-1:0]  kind;
    logic               uline;
  } sum_beat_t;

  typedef struct packed {
    logic [LUMA_W-1:0]  fl;
    logic [LUMA_W-1:0]  bl;
    lvl_t               fv;
    lvl_t               bv;
    logic [ROW_W-1:0]   row;
    logic [GLYPH_W-1:0] bits;
    logic [KIND_W-1:0]  kind;
    logic               uline;
  } lvl_beat_t;

  function automatic lvl_t lvl_down(lvl_t l);
    lvl_t r;
    unique case (l)
      LVL_WHITE:  r = LVL_DITHER;
      LVL_DITHER: r = LVL_BLACK;
      default:    r = LVL_BLACK;
    endcase
    return r;
  endfunction

  function automatic lvl_t lvl_up(lvl_t l);
    lvl_t r;
    unique case (l)
      LVL_BLACK:  r = LVL_DITHER;
      LVL_DITHER: r = LVL_WHITE;
      default:    r = LVL_WHITE;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/gre_luma_sum.sv]
// ----------------------------------------------------------------------------
// gre_luma_sum
// Stage one: cursor color select and weighted luma sums of both colors.
// ----------------------------------------------------------------------------
`default_nettype none

module gre_luma_sum
  import gre_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire logic [RGB_W-1:0]   fg_rgb,
  input  wire logic [RGB_W-1:0]   bg_rgb,
  input  wire logic [ROW_W-1:0]   row_index,
  input  wire logic [GLYPH_W-1:0] glyph_bits,
  input  wire logic [KIND_W-1:0]  width_kind,
  input  wire logic               underline,
  input  wire logic               is_cursor,
  input  wire logic [RGB_W-1:0]   cursor_fg,
  input  wire logic [RGB_W-1:0]   cursor_bg,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output sum_beat_t               dn_beat
);

  logic [RGB_W-1:0] fg_sel;
  logic [RGB_W-1:0] bg_sel;
  sum_beat_t        beat_next;

  function automatic logic [SUM_W-1:0] luma_sum(logic [RGB_W-1:0] rgb);
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
    r = SUM_W'(rgb[23:16]);
    g = SUM_W'(rgb[15:8]);
    b = SUM_W'(rgb[7:0]);
    return r * LUMA_R + g * LUMA_G + b * LUMA_B;
  endfunction

  assign up_ready = !dn_valid || dn_ready;
  assign fg_sel   = is_cursor ? cursor_fg : fg_rgb;
  assign bg_sel   = is_cursor ? cursor_bg : bg_rgb;

  always_comb begin
    beat_next.fg_sum = luma_sum(fg_sel);
    beat_next.bg_sum = luma_sum(bg_sel);
    beat_next.row    = row_index;
    beat_next.bits   = glyph_bits;
    beat_next.kind   = width_kind;
    beat_next.uline  = underline;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_beat <= beat_next;
    end
  end

endmodule

`default_nettype wire

[sv/gre_level.sv]
// ----------------------------------------------------------------------------
// gre_level
// Stage two: luma by division by 255 and the three gray levels.
// ----------------------------------------------------------------------------
`default_nettype none

module gre_level
  import gre_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire sum_beat_t up_beat,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output lvl_beat_t      dn_beat
);

  lvl_beat_t beat_next;

  // exact floor(s / 255) for s up to 65279, which covers every luma sum
  function automatic logic [LUMA_W-1:0] div255(logic [SUM_W-1:0] s);
    logic [SUM_W:0] t;
    t = {1'b0, s} + (SUM_W+1)'(s[SUM_W-1:8]) + (SUM_W+1)'(1);
    return t[SUM_W-1:8];
  endfunction

  function automatic lvl_t level_of(logic [LUMA_W-1:0] l);
    lvl_t r;
    if (l <= LUMA_BLACK_MAX) begin
      r = LVL_BLACK;
    end else if (l < LUMA_WHITE_MIN) begin
      r = LVL_DITHER;
    end else begin
      r = LVL_WHITE;
    end
    return r;
  endfunction

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    beat_next.fl    = div255(up_beat.fg_sum);
    beat_next.bl    = div255(up_beat.bg_sum);
    beat_next.fv    = level_of(beat_next.fl);
    beat_next.bv    = level_of(beat_next.bl);
    beat_next.row   = up_beat.row;
    beat_next.bits  = up_beat.bits;
    beat_next.kind  = up_beat.kind;
    beat_next.uline = up_beat.uline;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_beat <= beat_next;
    end
  end

endmodule

`default_nettype wire

[sv/gre_pixel.sv]
// ----------------------------------------------------------------------------
// gre_pixel
// Stage three: level separation, underline swap, bit select and dither.
// ----------------------------------------------------------------------------
`default_nettype none

module gre_pixel
  import gre_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire lvl_beat_t        up_beat,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output logic [PIX_W-1:0]      dn_pixels
);

  lvl_t             fv;
  lvl_t             bv;
  lvl_t             fv_sw;
  lvl_t             bv_sw;
  logic [PIX_W-1:0] pixels_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    fv = up_beat.fv;
    bv = up_beat.bv;
    if (up_beat.fv == up_beat.bv) begin
      if (up_beat.fl < up_beat.bl) begin
        if (up_beat.fv != LVL_BLACK) begin
          fv = lvl_down(up_beat.fv);
        end else begin
          bv = lvl_up(up_beat.bv);
        end
      end else begin
        if (up_beat.bv != LVL_BLACK) begin
          bv = lvl_down(up_beat.bv);
        end else begin
          fv = lvl_up(up_beat.fv);
        end
      end
    end
    if (ULINE_REACH && up_beat.uline && (up_beat.row == ULINE_ROW)) begin
      fv_sw = bv;
      bv_sw = fv;
    end else begin
      fv_sw = fv;
      bv_sw = bv;
    end
  end

  always_comb begin
    int   pad;
    int   pos;
    logic set;
    lvl_t lv;
    if (up_beat.kind == KIND_HALF) begin
      pad = PAD_HALF;
    end else if (up_beat.kind == KIND_WIDE) begin
      pad = PAD_WIDE;
    end else begin
      pad = PAD_DOUBLE;
    end
    pixels_next = '0;
    for (int w = 0; w < PIX_W; w++) begin
      pos = pad + CELL_W - 1 - w;
      set = 1'b0;
      if (pos >= 0 && pos < GLYPH_W) begin
        set = up_beat.bits[pos];
      end
      lv = set ? fv_sw : bv_sw;
      if (w < CELL_W) begin
        case (lv)
          LVL_BLACK:  pixels_next[w] = 1'b1;
          LVL_DITHER: pixels_next[w] = up_beat.row[0] != w[0];
          default:    pixels_next[w] = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_pixels <= pixels_next;
    end
  end

endmodule

`default_nettype wire

[sv/glyph_row_to_eink_gray_unit.sv]
// ----------------------------------------------------------------------------
// glyph_row_to_eink_gray_unit
// Renders one glyph row of a terminal cell into black, dither or white
// pixels for a three-level e-ink panel.
// ----------------------------------------------------------------------------
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------------------
//   in      | in_valid / in_stall   | fg_rgb bg_rgb row_index glyph_bits
//           |                       | width_kind underline is_cursor
//   out     | out_valid / out_stall | pixel_row
//   cfg     | cfg_we                | cfg_idx cfg_data
//
// three register stages: luma sums, luma and levels, pixel select.
// one beat per cycle while out_stall is low; a beat taken at the input is
// registered in the luma sums, luma and levels and pixel select stages in turn.
// rst clears the stage valid bits and loads the cursor colors.
// out_stall holds the last stage; each stage refills as soon as it drains,
// so in_stall rises only when every stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_row_to_eink_gray_unit
  import gre_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [RGB_W-1:0]     fg_rgb,
  input  wire logic [RGB_W-1:0]     bg_rgb,
  input  wire logic [ROW_W-1:0]     row_index,
  input  wire logic [GLYPH_W-1:0]   glyph_bits,
  input  wire logic [KIND_W-1:0]    width_kind,
  input  wire logic                 underline,
  input  wire logic                 is_cursor,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [PIX_W-1:0]          pixel_row,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [RGB_W-1:0]     cfg_data
);

  logic [RGB_W-1:0] cursor_fg;
  logic [RGB_W-1:0] cursor_bg;
  logic             in_ready;
  logic             sum_valid;
  logic             sum_ready;
  sum_beat_t        sum_beat;
  logic             lvl_valid;
  logic             lvl_ready;
  lvl_beat_t        lvl_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_fg <= CURSOR_FG_RESET;
      cursor_bg <= CURSOR_BG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CURSOR_FG: cursor_fg <= cfg_data;
        REG_CURSOR_BG: cursor_bg <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = !in_ready;

  gre_luma_sum u_sum (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (in_valid),
    .up_ready   (in_ready),
    .fg_rgb     (fg_rgb),
    .bg_rgb     (bg_rgb),
    .row_index  (row_index),
    .glyph_bits (glyph_bits),
    .width_kind (width_kind),
    .underline  (underline),
    .is_cursor  (is_cursor),
    .cursor_fg  (cursor_fg),
    .cursor_bg  (cursor_bg),
    .dn_valid   (sum_valid),
    .dn_ready   (sum_ready),
    .dn_beat    (sum_beat)
  );

  gre_level u_level (
    .clk      (clk),
    .rst      (rst),
    .up_valid (sum_valid),
    .up_ready (sum_ready),
    .up_beat  (sum_beat),
    .dn_valid (lvl_valid),
    .dn_ready (lvl_ready),
    .dn_beat  (lvl_beat)
  );

  gre_pixel u_pixel (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (lvl_valid),
    .up_ready  (lvl_ready),
    .up_beat   (lvl_beat),
    .dn_valid  (out_valid),
    .dn_ready  (!out_stall),
    .dn_pixels (pixel_row)
  );

endmodule

`default_nettype wire
